[src/fqkd_pkg.sv]
// ----------------------------------------------------------------------------
// fqkd_pkg
// shared constants, codes and types of the ordered key queue with delete
// ----------------------------------------------------------------------------
package fqkd_pkg;

   localparam int FQKD_DEPTH    = 16;
   localparam int FQKD_KEY_BITS = 32;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_PUSH   = 2'd0;
   localparam cmd_type CMD_REMOVE = 2'd1;
   localparam cmd_type CMD_POP    = 2'd2;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   // per-beat control broadcast to every cell
   typedef struct packed {
      logic push_go;
      logic pop_go;
      logic remove;
   } cell_ctrl_type;

endpackage

[src/fqkd_ifs.sv]
// ----------------------------------------------------------------------------
// fqkd channel interfaces
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface fqkd_req_if import fqkd_pkg::*; ;
   logic             valid;
   logic             ready;
   cmd_type          cmd;
   logic [KEY_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink (input valid, input cmd, input key, output ready);
endinterface

interface fqkd_rsp_if import fqkd_pkg::*; ;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [KEY_W-1:0]   head_key;
   logic               head_valid;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output status, output head_key, output head_valid,
                   output count, input ready);
   modport sink (input valid, input status, input head_key, input head_valid,
                 input count, output ready);
endinterface

[src/fqkd_cell.sv]
// ----------------------------------------------------------------------------
// fqkd_cell
// one queue slot: holds a key, compares it, loads on push, shifts on pop or delete
// ----------------------------------------------------------------------------
module fqkd_cell import fqkd_pkg::*; #(
   parameter int KEY_BITS = FQKD_KEY_BITS,
   parameter int FILL_W   = 5,
   parameter int IDX      = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [FILL_W-1:0]   fill,
   input  logic [KEY_BITS-1:0] search_key,
   input  logic [KEY_BITS-1:0] next_key,
   input  logic                found_in,
   output logic                found_out,
   output logic [KEY_BITS-1:0] key_out
);

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_in;
   logic                occupied;
   logic                match;
   logic                shift;
   logic                load;

   assign occupied  = fill > FILL_W'(IDX);
   assign match     = occupied && (key_ff == search_key);
   assign found_out = found_in || match;
   assign shift     = ctrl.pop_go || (ctrl.remove && found_out);
   assign load      = ctrl.push_go && (fill == FILL_W'(IDX));
   assign key_out   = key_ff;

   always_comb begin
      key_in = key_ff;
      if (load) begin
         key_in = search_key;
      end else if (shift) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

[src/fifo_queue_with_key_delete_top.sv]
// ----------------------------------------------------------------------------
// fifo_queue_with_key_delete_top
// ordered key queue: push at tail, pop head, delete first matching key
// ----------------------------------------------------------------------------
// channel    dir   beat contents
// req_chan   in    cmd, key
// rsp_chan   out   status, head_key, head_valid, count
//
// one command beat per cycle unless a result beat waits untaken; the cell row
// updates at the accepting edge and the result beat is valid in the next cycle
// delete searches all cells at once through the found chain along the row
// a waiting result beat holds off new commands until it is taken
// synchronous reset empties the queue and holds off commands; cell contents
// are not cleared
// ----------------------------------------------------------------------------
module fifo_queue_with_key_delete_top import fqkd_pkg::*; #(
   parameter int DEPTH    = FQKD_DEPTH,
   parameter int KEY_BITS = FQKD_KEY_BITS
) (
   input logic        clock,
   input logic        reset,
   fqkd_req_if.sink   req_chan,
   fqkd_rsp_if.source rsp_chan
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic                accept;
   logic                not_full;
   logic                not_empty;
   logic                hit;
   logic [KEY_BITS-1:0] search_key;
   cell_ctrl_type       ctrl;
   logic [KEY_BITS-1:0] cell_key [DEPTH];
   logic                found    [DEPTH+1];

   assign req_chan.ready = !reset && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign not_full       = fill_ff < FILL_W'(DEPTH);
   assign not_empty      = fill_ff != '0;
   assign search_key     = KEY_BITS'(req_chan.key);
   assign hit            = found[DEPTH];
   assign found[0]       = 1'b0;

   always_comb begin
      ctrl      = '0;
      status_in = ST_DONE;
      fill_in   = fill_ff;
      case (req_chan.cmd)
         CMD_PUSH: begin
            ctrl.push_go = accept && not_full;
            status_in    = not_full ? ST_DONE : ST_FULL;
            if (ctrl.push_go) begin
               fill_in = fill_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            ctrl.remove = accept;
            status_in   = hit ? ST_DONE : ST_NOT_FOUND;
            if (accept && hit) begin
               fill_in = fill_ff - 1'b1;
            end
         end
         CMD_POP: begin
            ctrl.pop_go = accept && not_empty;
            status_in   = not_empty ? ST_DONE : ST_UNDERFLOW;
            if (ctrl.pop_go) begin
               fill_in = fill_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] next_key;
      if (i == DEPTH - 1) begin : g_last
         assign next_key = cell_key[i];
      end else begin : g_mid
         assign next_key = cell_key[i+1];
      end

      fqkd_cell #(
         .KEY_BITS (KEY_BITS),
         .FILL_W   (FILL_W),
         .IDX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .fill       (fill_ff),
         .search_key (search_key),
         .next_key   (next_key),
         .found_in   (found[i]),
         .found_out  (found[i+1]),
         .key_out    (cell_key[i])
      );
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.head_valid = not_empty;
   assign rsp_chan.head_key   = not_empty ? KEY_W'(cell_key[0]) : '0;
   assign rsp_chan.count      = COUNT_W'(fill_ff);

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill beyond depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_FULL) |-> fill_ff == FILL_W'(DEPTH))
      else $error("full status with room left");

   a_underflow_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_UNDERFLOW) |-> fill_ff == '0)
      else $error("underflow status on non-empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push_go |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("push did not grow queue");

   a_miss_holds: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove && !hit |=> $stable(fill_ff))
      else $error("missed delete changed fill");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the ordered key queue with delete by key. A short directed
// run hits the empty and full limits, duplicate keys, removal misses and the
// unused command code. A random run then sweeps the fill level up and down
// with keys drawn mostly from a small pool, so that removes often hit. Every
// command beat goes through a queue model, and each result beat is compared
// field by field with the oldest predicted result. The sender idles in bursts
// and the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module tb;
   import fqkd_pkg::*;

   localparam int          RANDOM_ITEMS = 1150;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          SETTLE       = 20;
   localparam cmd_type     CMD_NOP      = 2'd3;
   localparam logic [63:0] KEY_MASK     = {64{1'b1}} >> (64 - FQKD_KEY_BITS);

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      status_type         status;
      key_type            head_key;
      logic               head_valid;
      logic [COUNT_W-1:0] count;
   } queue_reply_type;

   typedef struct {
      cmd_type cmd;
      key_type key;
      bit      wait_idle;
   } cmd_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqkd_req_if req_if ();
   fqkd_rsp_if rsp_if ();

   fifo_queue_with_key_delete_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   cmd_beat_type    cmd_beat_q[$];
   queue_reply_type reply_expect_q[$];
   key_type         model_keys[$];
   key_type         plan_keys[$];
   key_type         key_pool[8];

   int   total_beats = 0;
   int   beats_taken = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   bit   req_taken = 1'b0;
   bit   hold_rsp = 1'b0;
   int   burst_left = 1;
   int   gap_left = 0;
   int   stall_mode = 0;
   int   stall_mode_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue model: applies one command to keys and returns the result beat
   function automatic queue_reply_type apply_queue_op(ref key_type keys[$],
                                                      input cmd_type cmd,
                                                      input key_type key);
      queue_reply_type r;
      key_type         k;
      int              hit;
      k        = key & KEY_MASK[KEY_W-1:0];
      r.status = ST_DONE;
      hit      = -1;
      case (cmd)
         CMD_PUSH: begin
            if (keys.size() >= FQKD_DEPTH) r.status = ST_FULL;
            else keys.insert(keys.size(), k);
         end
         CMD_REMOVE: begin
            foreach (keys[i]) if (hit < 0 && keys[i] == k) hit = i;
            if (hit < 0) r.status = ST_NOT_FOUND;
            else keys.delete(hit);
         end
         CMD_POP: begin
            if (keys.size() == 0) r.status = ST_UNDERFLOW;
            else void'(keys.pop_front());
         end
         default: ;
      endcase
      r.head_valid = keys.size() > 0;
      r.head_key   = (keys.size() > 0) ? keys[0] : '0;
      r.count      = COUNT_W'(keys.size());
      return r;
   endfunction

   function automatic void plan_beat(cmd_type cmd, key_type key, bit wait_idle);
      cmd_beat_type b;
      b.cmd       = cmd;
      b.key       = key;
      b.wait_idle = wait_idle;
      cmd_beat_q.insert(cmd_beat_q.size(), b);
      total_beats++;
      void'(apply_queue_op(plan_keys, cmd, key));
   endfunction

   function automatic key_type pick_key();
      if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic flag_reply_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // stimulus plan
   initial begin
      cmd_type cmd;
      key_type key;
      bit      growing;
      int      pick;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 8; i++) key_pool[i] = $urandom;

      // empty queue corners, duplicates, misses
      plan_beat(CMD_POP, 32'h1234_5678, 1'b0);
      plan_beat(CMD_REMOVE, 32'h0000_0007, 1'b0);
      plan_beat(CMD_NOP, 32'hFFFF_FFFF, 1'b0);
      plan_beat(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
      plan_beat(CMD_PUSH, 32'h0000_0000, 1'b0);
      plan_beat(CMD_PUSH, 32'h0000_0000, 1'b0);
      plan_beat(CMD_REMOVE, 32'h0000_0000, 1'b0);
      plan_beat(CMD_REMOVE, 32'h0000_0007, 1'b0);
      plan_beat(CMD_POP, 32'hFFFF_FFFF, 1'b0);
      // fill up to the limit, then push into a full queue
      for (int i = 0; i < FQKD_DEPTH - 1; i++)
         plan_beat(CMD_PUSH, (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i, 1'b0);
      plan_beat(CMD_PUSH, 32'hDEAD_BEEF, 1'b0);
      plan_beat(CMD_NOP, 32'h0, 1'b0);

      growing = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (plan_keys.size() == FQKD_DEPTH) growing = 1'b0;
         else if (plan_keys.size() == 0) growing = 1'b1;
         else if ($urandom_range(0, 40) == 0) growing = !growing;
         pick = $urandom_range(0, 99);
         if (pick < 5) cmd = CMD_NOP;
         else if (pick < (growing ? 60 : 25)) cmd = CMD_PUSH;
         else if (pick < (growing ? 80 : 60)) cmd = CMD_REMOVE;
         else cmd = CMD_POP;
         key = pick_key();
         if (cmd == CMD_REMOVE && plan_keys.size() != 0 && $urandom_range(0, 3) != 0)
            key = plan_keys[$urandom_range(0, plan_keys.size() - 1)];
         plan_beat(cmd, key, (n % 230) == 0);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (beats_taken == total_beats);
      wait (reply_expect_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && reply_expect_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      int held;
      wait (!reset);
      repeat (400) @(posedge clock);
      hold_rsp = 1'b1;
      held = 0;
      while (held < 300) begin
         @(posedge clock);
         held++;
      end
      hold_rsp = 1'b0;
   end

   // command driver
   always @(negedge clock) begin
      cmd_beat_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.cmd   <= CMD_PUSH;
         req_if.key   <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (cmd_beat_q.size() != 0 &&
                      !(cmd_beat_q[0].wait_idle && reply_expect_q.size() != 0)) begin
            nxt = cmd_beat_q.pop_front();
            req_if.cmd   <= nxt.cmd;
            req_if.key   <= nxt.key;
            req_if.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 150);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (cycle_count % 3) != 0;
         endcase
         rsp_if.ready <= hold_rsp ? 1'b0 : rdy;
      end
   end

   // result check and prediction at the accepting edge
   always @(posedge clock) begin
      queue_reply_type want;
      cycle_count++;
      req_taken = 1'b0;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (reply_expect_q.size() == 0) begin
               flag_reply_error("result beat with nothing expected");
            end else begin
               want = reply_expect_q.pop_front();
               if (rsp_if.status !== want.status)
                  flag_reply_error($sformatf("status exp %0d got %0d",
                                             want.status, rsp_if.status));
               if (rsp_if.head_key !== want.head_key)
                  flag_reply_error($sformatf("head_key exp %h got %h",
                                             want.head_key, rsp_if.head_key));
               if (rsp_if.head_valid !== want.head_valid)
                  flag_reply_error($sformatf("head_valid exp %0d got %0d",
                                             want.head_valid, rsp_if.head_valid));
               if (rsp_if.count !== want.count)
                  flag_reply_error($sformatf("count exp %0d got %0d",
                                             want.count, rsp_if.count));
            end
         end
         if (req_if.valid && req_if.ready) begin
            reply_expect_q.insert(reply_expect_q.size(),
                                  apply_queue_op(model_keys, req_if.cmd, req_if.key));
            beats_taken++;
            req_taken = 1'b1;
         end
      end
   end

endmodule

[files.f]
src/fqkd_pkg.sv
src/fqkd_ifs.sv
src/fqkd_cell.sv
src/fifo_queue_with_key_delete_top.sv
dv/tb.sv
